### hw/rtl/scalar_kalman_filter_assert.svh
// assertion macros for the scalar kalman filter
// expects signals clk and rst in the scope where a macro is used
`ifndef SCALAR_KALMAN_FILTER_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_ASSERT_SVH

// same-cycle implication
`define SKF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/skf_pkg.sv
// shared types and constants for the scalar kalman filter
// no dependencies
`default_nettype none

package skf_pkg;

  localparam int DATA_WIDTH_DEF  = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  // configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROCESS_NOISE    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MEASURE_NOISE    = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INITIAL_ESTIMATE = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // take sample, predict covariance
    logic prep;      // set up divider and difference
    logic div_step;  // one restoring division step
    logic gain;      // select gain, arm multipliers
    logic mul_step;  // one shift-add step of both products
    logic update;    // write estimate, covariance and result
  } skf_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_hold;  // result register full and stalled
  } skf_status_t;

endpackage

`default_nettype wire

### hw/rtl/scalar_kalman_filter.sv
// scalar kalman filter: one signed fixed-point sample in, one estimate out
// one sample at a time: the next sample is taken only after the previous result is written,
//   which follows the serial gain divider (FRAC_BITS steps) and the shift-add multipliers
//   (FRAC_BITS+1 steps) and waits while a stalled result is still held
// reset: synchronous, clears estimate, covariance and started flag; registers take
//   process_noise 0, measure_noise 1.0, initial_estimate 0
`default_nettype none

`include "scalar_kalman_filter_assert.svh"

module scalar_kalman_filter
  import skf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // sample channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] sample,
  // estimate channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] estimate,
  // register write port
  input  logic                         cfg_wen,
  input  logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [DATA_WIDTH-1:0]        cfg_data
);

  // measurement noise resets to 1.0 in q format
  localparam logic [DATA_WIDTH-1:0] MEASURE_NOISE_RST = DATA_WIDTH'(1) << FRAC_BITS;

  logic        [DATA_WIDTH-1:0] process_noise;
  logic        [DATA_WIDTH-1:0] measure_noise;
  logic signed [DATA_WIDTH-1:0] initial_estimate;

  skf_cmd_t    cmd;
  skf_status_t status;

  // register file; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise    <= '0;
      measure_noise    <= MEASURE_NOISE_RST;
      initial_estimate <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_PROCESS_NOISE:    process_noise    <= cfg_data;
        REG_MEASURE_NOISE:    measure_noise    <= cfg_data;
        REG_INITIAL_ESTIMATE: initial_estimate <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // controller: accepts a transfer only when idle, then steps the datapath
  skf_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: prediction, gain division, correction, result register
  skf_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .sample           (sample),
    .process_noise    (process_noise),
    .measure_noise    (measure_noise),
    .initial_estimate (initial_estimate),
    .estimate         (estimate),
    .out_valid        (out_valid),
    .out_stall        (out_stall)
  );

  // after an input transfer the block stays busy for the whole computation
  `SKF_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "ready right after accept")
  // a new result appears exactly as the controller returns to idle
  `SKF_ASSERT_NOW(a_idle_on_result, $rose(out_valid), !in_stall, "result without return to idle")
  // a new result only comes out of a busy period
  `SKF_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result while idle")

endmodule

`default_nettype wire

### hw/rtl/skf_ctrl.sv
// sequencing state machine for the scalar kalman filter
// depends on skf_pkg
`default_nettype none

module skf_ctrl
  import skf_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  skf_status_t status,
  output skf_cmd_t    cmd
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(FRAC_BITS);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV  = 6'b000100,
    S_GAIN = 6'b001000,
    S_MUL  = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) begin
          state_next = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd.gain   = 1'b1;
        cnt_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == MUL_LAST) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        if (!status.out_hold) begin
          cmd.update = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/skf_dp.sv
// datapath of the scalar kalman filter: state, divider, serial multipliers
// depends on skf_pkg
`default_nettype none

module skf_dp
  import skf_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  skf_cmd_t                     cmd,
  output skf_status_t                  status,
  input  logic signed [DATA_WIDTH-1:0] sample,
  input  logic        [DATA_WIDTH-1:0] process_noise,
  input  logic        [DATA_WIDTH-1:0] measure_noise,
  input  logic signed [DATA_WIDTH-1:0] initial_estimate,
  output logic signed [DATA_WIDTH-1:0] estimate,
  output logic                         out_valid,
  input  logic                         out_stall
);

  localparam int DW = DATA_WIDTH;
  localparam int RW = DW + 2;           // division remainder
  localparam int GW = FRAC_BITS + 1;    // gain, q0.frac plus the one bit
  localparam int PW = DW + 1 + GW;      // signed difference times gain
  localparam int CW = DW + GW;          // covariance times one minus gain
  localparam int XW = DW + 2;           // widened estimate sum
  localparam logic [GW-1:0] ONE_G = GW'(1) << FRAC_BITS;

  logic signed [DW-1:0]        est;
  logic        [DW-1:0]        cov;
  logic                        started;
  logic signed [DW-1:0]        samp;
  logic        [DW-1:0]        pm;
  logic        [DW:0]          den;
  logic        [RW-1:0]        rem;
  logic        [FRAC_BITS-1:0] q;
  logic signed [DW:0]          diff;
  logic        [GW-1:0]        gm;
  logic        [GW-1:0]        hm;
  logic signed [PW-1:0]        pacc;
  logic        [CW-1:0]        cacc;

  logic        [DW:0]   pm_sum;
  logic        [RW-1:0] rem_sh;
  logic                 rem_ge;
  logic        [GW-1:0] g_sel;
  logic signed [PW-1:0] diff_ext;
  logic signed [PW-1:0] padd;
  logic        [CW-1:0] cadd;
  logic signed [XW-1:0] est_ext;
  logic signed [XW-1:0] nx_wide;
  logic signed [DW-1:0] nx;

  // saturating covariance prediction
  assign pm_sum = {1'b0, cov} + {1'b0, process_noise};

  // restoring division step
  assign rem_sh = rem << 1;
  assign rem_ge = (rem_sh >= {1'b0, den});

  // zero divisor gives no gain, zero measurement noise gives full gain
  always_comb begin
    if (den == '0) begin
      g_sel = '0;
    end else if (measure_noise == '0) begin
      g_sel = ONE_G;
    end else begin
      g_sel = {1'b0, q};
    end
  end

  // msb-first shift-add partial products
  assign diff_ext = PW'(diff);

  always_comb begin
    if (gm[GW-1]) begin
      padd = diff_ext;
    end else begin
      padd = '0;
    end
    if (hm[GW-1]) begin
      cadd = CW'(pm);
    end else begin
      cadd = '0;
    end
  end

  // floor of the scaled step, then clamp to the signed range
  assign est_ext = XW'(est);
  assign nx_wide = est_ext + pacc[PW-1:FRAC_BITS];

  always_comb begin
    if (!nx_wide[XW-1] && (nx_wide[XW-2:DW-1] != '0)) begin
      nx = {1'b0, {(DW-1){1'b1}}};
    end else if (nx_wide[XW-1] && (nx_wide[XW-2:DW-1] != '1)) begin
      nx = {1'b1, {(DW-1){1'b0}}};
    end else begin
      nx = nx_wide[DW-1:0];
    end
  end

  assign status.out_hold = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      est       <= '0;
      cov       <= '0;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        started <= 1'b1;
        if (!started) begin
          est <= initial_estimate;
        end
      end
      if (cmd.update) begin
        est       <= nx;
        cov       <= cacc[FRAC_BITS +: DW];
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      samp <= sample;
      if (pm_sum[DW]) begin
        pm <= '1;
      end else begin
        pm <= pm_sum[DW-1:0];
      end
    end
    if (cmd.prep) begin
      den  <= {1'b0, pm} + {1'b0, measure_noise};
      rem  <= {2'b00, pm};
      q    <= '0;
      diff <= (DW + 1)'(samp) - (DW + 1)'(est);
    end
    if (cmd.div_step) begin
      if (rem_ge) begin
        rem <= rem_sh - {1'b0, den};
      end else begin
        rem <= rem_sh;
      end
      q <= {q[FRAC_BITS-2:0], rem_ge};
    end
    if (cmd.gain) begin
      gm   <= g_sel;
      hm   <= ONE_G - g_sel;
      pacc <= '0;
      cacc <= '0;
    end
    if (cmd.mul_step) begin
      pacc <= (pacc <<< 1) + padd;
      cacc <= (cacc << 1) + cadd;
      gm   <= gm << 1;
      hm   <= hm << 1;
    end
    if (cmd.update) begin
      estimate <= nx;
    end
  end

endmodule

`default_nettype wire

### bench/testbench.sv
// self-checking bench for the scalar kalman filter: directed rows, then random sample streams
// depends on skf_pkg and the scalar_kalman_filter rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skf_pkg::*;

  localparam int W = DATA_WIDTH_DEF;
  localparam int F = FRAC_BITS_DEF;
  localparam logic [63:0] GAIN_ONE = 64'd1 << F;
  localparam logic [63:0] FRAC_MASK = GAIN_ONE - 64'd1;
  localparam logic [63:0] COV_MAX = (64'd1 << W) - 64'd1;
  localparam longint EST_MAX = (longint'(1) <<< (W - 1)) - 1;
  localparam longint EST_MIN = -(longint'(1) <<< (W - 1));
  // index past the register list, writes to it must be dropped
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 11;
  localparam int SAMPLES_PER_PHASE = 50;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [W-1:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [W-1:0] estimate;
  logic cfg_wen = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [W-1:0] cfg_data = '0;

  // idle percentages of each side, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;

  // filter state and registers as the bench expects them
  logic [W-1:0] q_noise = '0;
  logic [W-1:0] r_noise = W'(GAIN_ONE);
  logic [W-1:0] init_estimate = '0;
  logic signed [W-1:0] filt_estimate = '0;
  logic [W-1:0] filt_covariance = '0;
  logic filt_started = 1'b0;

  logic [W-1:0] pending_estimates[$];

  scalar_kalman_filter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .estimate  (estimate),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // a * g / 2^F with g at most 1.0; split so nothing overflows 64 bits
  function automatic logic [63:0] scale_by_gain(input logic [63:0] a, input logic [63:0] g,
                                                input bit round_up);
    logic [63:0] part;
    logic [63:0] low_term;
    part = (a & FRAC_MASK) * g;
    low_term = part >> F;
    // negative steps round away from the old estimate so the total floors
    if (round_up && (part & FRAC_MASK) != 0) low_term = low_term + 64'd1;
    return (a >> F) * g + low_term;
  endfunction

  // one filter step: predict, gain, correct; updates the expected state
  function automatic logic [W-1:0] next_estimate(input logic signed [W-1:0] meas);
    logic [63:0] cov_pred;
    logic [63:0] divisor;
    logic [63:0] rem;
    logic [63:0] gain;
    longint prev;
    longint diff;
    longint upd;
    // first sample starts from the initial estimate register
    if (!filt_started) begin
      filt_estimate = init_estimate;
      filt_started = 1'b1;
    end
    prev = filt_estimate;
    // covariance prediction saturates at all ones
    cov_pred = 64'(filt_covariance) + 64'(q_noise);
    if (cov_pred > COV_MAX) cov_pred = COV_MAX;
    divisor = cov_pred + 64'(r_noise);
    // gain = P / (P + R) as a fraction of 2^F, zero on a zero divisor
    if (divisor == 0) begin
      gain = '0;
    end else if (cov_pred >= divisor) begin
      gain = GAIN_ONE;
    end else begin
      rem = cov_pred;
      gain = '0;
      for (int i = 0; i < F; i++) begin
        rem = rem << 1;
        gain = gain << 1;
        if (rem >= divisor) begin
          rem = rem - divisor;
          gain[0] = 1'b1;
        end
      end
    end
    diff = meas - prev;
    if (diff >= 0) begin
      upd = prev + longint'(scale_by_gain(64'(diff), gain, 1'b0));
    end else begin
      upd = prev - longint'(scale_by_gain(64'(-diff), gain, 1'b1));
    end
    if (upd > EST_MAX) upd = EST_MAX;
    if (upd < EST_MIN) upd = EST_MIN;
    filt_covariance = W'(scale_by_gain(cov_pred, GAIN_ONE - gain, 1'b0));
    filt_estimate = W'(upd);
    return W'(upd);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers; every task is entered and left just after a falling edge
  // ---------------------------------------------------------------------------

  task automatic send_sample(input logic [W-1:0] value, input bit use_lit,
                             input logic [W-1:0] lit);
    logic [W-1:0] predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    // hold the sample until the transfer happens
    do @(posedge clk); while (in_stall);
    predicted = next_estimate(value);
    pending_estimates.push_back(use_lit ? lit : predicted);
    @(negedge clk);
  endtask

  // drop valid and wait for every outstanding estimate
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_estimates.size() != 0) @(negedge clk);
  endtask

  // one register write; wen drops for a cycle so back-to-back writes never collide
  task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [W-1:0] value);
    cfg_wen <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_PROCESS_NOISE:    q_noise = value;
      REG_MEASURE_NOISE:    r_noise = value;
      REG_INITIAL_ESTIMATE: init_estimate = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
    @(negedge clk);
  endtask

  // noise variances: zero, small, anything, all ones
  function automatic logic [W-1:0] pick_noise;
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return W'($urandom);
      default: return W'($urandom_range(32'h0004_0000));
    endcase
  endfunction

  // sensor-like samples near the current estimate, plus wide values and extremes
  function automatic logic [W-1:0] pick_sample;
    longint span;
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) begin
      span = ($urandom_range(1) == 0) ? 64'h0001_0000 : 64'h0100_0000;
      return W'(longint'(filt_estimate) + longint'($urandom_range(32'(2 * span))) - span);
    end else if (roll < 85) begin
      return W'($urandom);
    end
    case ($urandom_range(3))
      0:       return {1'b0, {(W-1){1'b1}}};
      1:       return {1'b1, {(W-1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // directed rows; literal expectations only where gain is plainly 0 or 1.0
  // ---------------------------------------------------------------------------

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_INDEX_WIDTH-1:0] index;
    logic [W-1:0]               value;
    logic                       has_lit;
    logic [W-1:0]               lit;
  } vector_row_t;

  localparam int N_DIRECTED = 26;

  vector_row_t directed_rows [N_DIRECTED] = '{
    // q stays 0 and the covariance 0, so the gain is 0 and the start value holds
    '{ROW_WRITE,  REG_INITIAL_ESTIMATE, 32'h8000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b1, 32'h8000_0000},
    // start value written after the first sample must not take effect
    '{ROW_WRITE,  REG_INITIAL_ESTIMATE, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0001_2345, 1'b1, 32'h8000_0000},
    // zero divisor: P + R is 0
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'h0000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000},
    // write past the register list is ignored
    '{ROW_WRITE,  REG_UNUSED, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h5555_AAAA, 1'b1, 32'h8000_0000},
    // zero measurement noise: gain 1.0, estimate tracks the sample exactly
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'h0001_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
    '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b1, 32'h8000_0000},
    '{ROW_SAMPLE, '0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
    '{ROW_SAMPLE, '0, 32'h0000_0001, 1'b1, 32'h0000_0001},
    // fractional gain, both step directions
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'h0001_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0010_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'hFFF0_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0003, 1'b0, '0},
    // covariance prediction saturates
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_WRITE,  REG_MEASURE_NOISE, 32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h8000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h1234_5678, 1'b0, '0},
    // no process noise: the covariance decays step by step
    '{ROW_WRITE,  REG_PROCESS_NOISE, 32'h0000_0000, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'hABCD_EF01, 1'b0, '0},
    '{ROW_SAMPLE, '0, 32'h0000_0000, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  always @(negedge clk) begin
    out_stall <= (!rst && $urandom_range(99) < recv_idle_pct);
  end

  // compare each estimate transfer with the oldest expectation
  always @(posedge clk) begin : estimate_check
    logic [W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_estimates.size() == 0) begin
        note_mismatch($sformatf("estimate %h with nothing outstanding", estimate));
      end else begin
        want = pending_estimates.pop_front();
        if (estimate !== want) begin
          note_mismatch($sformatf("estimate expected %h got %h", want, estimate));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows with a slow receiver
    send_idle_pct = 9;
    recv_idle_pct = 78;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        drain();
        write_reg(directed_rows[k].index, directed_rows[k].value);
      end else begin
        send_sample(directed_rows[k].value, directed_rows[k].has_lit, directed_rows[k].lit);
      end
    end

    // random streams: slow receiver, then slow sender, then full rate
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph < 4) begin
        send_idle_pct = 9;
        recv_idle_pct = 78;
      end else if (ph < 8) begin
        send_idle_pct = 78;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      write_reg(REG_PROCESS_NOISE, pick_noise());
      write_reg(REG_MEASURE_NOISE, pick_noise());
      write_reg(REG_INITIAL_ESTIMATE, W'($urandom));
      if ($urandom_range(2) == 0) write_reg(REG_UNUSED, W'($urandom));
      repeat (SAMPLES_PER_PHASE) send_sample(pick_sample(), 1'b0, '0);
    end

    drain();
    // any late or extra estimate still gets caught by the checker
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS scalar_kalman_filter");
    end else begin
      $display("FAIL scalar_kalman_filter");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL scalar_kalman_filter");
    $finish;
  end

endmodule
